/* design/tcgr_pkg.sv */
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types, codes and widths of the text console glyph renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

    // default geometry and font parameters
    localparam int GLYPH_HEIGHT_DEF = 16;
    localparam int GLYPH_COUNT_DEF  = 256;
    localparam int MAX_COLUMNS_DEF  = 256;
    localparam int MAX_ROWS_DEF     = 128;

    // word field widths
    localparam int ACTION_W = 2;
    localparam int CODE_W   = 8;
    localparam int GLINE_W  = 4;
    localparam int FONT_W   = 8;
    localparam int KIND_W   = 2;
    localparam int ADDR_W   = 48;
    localparam int PIXEL_W  = 32;
    localparam int PIXELS   = 8;

    // configuration register widths
    localparam int PITCH_W = 16;
    localparam int TCOLS_W = 9;
    localparam int TROWS_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // bytes per cell row: eight 4-byte pixels
    localparam int CELL_SHIFT = 5;
    localparam int TAB_STEP   = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLUMNS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ROWS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 3'd6;

    // configuration reset values
    localparam logic [TCOLS_W-1:0] TEXT_COLUMNS_RST = 9'd80;
    localparam logic [TROWS_W-1:0] TEXT_ROWS_RST    = 8'd25;
    localparam logic [PIXEL_W-1:0] FG_COLOR_RST     = 32'h00C0_C0C0;

    // control characters
    localparam logic [CODE_W-1:0] CHAR_LF  = 8'h0A;
    localparam logic [CODE_W-1:0] CHAR_CR  = 8'h0D;
    localparam logic [CODE_W-1:0] CHAR_TAB = 8'h09;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT   = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    typedef enum logic [KIND_W-1:0] {
        KIND_GLYPH  = 2'd0,
        KIND_SCROLL = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD,
        S_ADDR,
        S_DRAW,
        S_REQ
    } t_state;

endpackage

/* design/tcgr_char_if.sv */
// ----------------------------------------------------------------------------
// tcgr_char_if
// Input channel: one character, command or font row per word.
// ----------------------------------------------------------------------------
interface tcgr_char_if;
    logic                          valid;
    logic                          ready;
    logic [tcgr_pkg::ACTION_W-1:0] action;
    logic [tcgr_pkg::CODE_W-1:0]   char_code;
    logic [tcgr_pkg::GLINE_W-1:0]  glyph_line;
    logic [tcgr_pkg::FONT_W-1:0]   font_bits;

    modport source (
        output valid, action, char_code, glyph_line, font_bits,
        input  ready
    );

    modport sink (
        input  valid, action, char_code, glyph_line, font_bits,
        output ready
    );
endinterface

/* design/tcgr_req_if.sv */
// ----------------------------------------------------------------------------
// tcgr_req_if
// Output channel: one glyph row write or blitter request per word.
// ----------------------------------------------------------------------------
interface tcgr_req_if;
    logic                         valid;
    logic                         ready;
    logic [tcgr_pkg::KIND_W-1:0]  kind;
    logic [tcgr_pkg::ADDR_W-1:0]  pixel_address;
    logic [tcgr_pkg::PIXEL_W-1:0] pixel_0;
    logic [tcgr_pkg::PIXEL_W-1:0] pixel_1;
    logic [tcgr_pkg::PIXEL_W-1:0] pixel_2;
    logic [tcgr_pkg::PIXEL_W-1:0] pixel_3;
    logic [tcgr_pkg::PIXEL_W-1:0] pixel_4;
    logic [tcgr_pkg::PIXEL_W-1:0] pixel_5;
    logic [tcgr_pkg::PIXEL_W-1:0] pixel_6;
    logic [tcgr_pkg::PIXEL_W-1:0] pixel_7;
    logic                         last;

    modport source (
        output valid, kind, pixel_address, pixel_0, pixel_1, pixel_2, pixel_3,
               pixel_4, pixel_5, pixel_6, pixel_7, last,
        input  ready
    );

    modport sink (
        input  valid, kind, pixel_address, pixel_0, pixel_1, pixel_2, pixel_3,
               pixel_4, pixel_5, pixel_6, pixel_7, last,
        output ready
    );
endinterface

/* design/text_console_glyph_renderer.sv */
// ----------------------------------------------------------------------------
// text_console_glyph_renderer
// Cursor-tracking text console that turns characters into glyph row writes
// and scroll / clear requests for an external blitter.
// ----------------------------------------------------------------------------
// A printable character runs S_PROD, S_ADDR and S_DRAW, and S_REQ if it
// scrolls; output stalls hold S_DRAW and S_REQ. S_PROD does the line multiply,
// S_ADDR forms the start address and prefetches the first font row, then
// S_DRAW reads one glyph row per cycle out of the font RAM while the output is
// not stalled, as one adder steps the address by the line pitch. Newline,
// carriage return, tab, font loads and ignored words end in S_IDLE, or S_REQ
// if they scroll; a clear uses S_REQ. The input is not ready outside S_IDLE.
module text_console_glyph_renderer #(
    parameter int GLYPH_HEIGHT = tcgr_pkg::GLYPH_HEIGHT_DEF,
    parameter int GLYPH_COUNT  = tcgr_pkg::GLYPH_COUNT_DEF,
    parameter int MAX_COLUMNS  = tcgr_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS     = tcgr_pkg::MAX_ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tcgr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcgr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tcgr_char_if.sink                       i_char,
    tcgr_req_if.source                      o_req
);
    import tcgr_pkg::*;

    localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
    localparam int FI_W   = $clog2(FONT_DEPTH);
    localparam int Y_W    = $clog2(GLYPH_HEIGHT);
    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int CT_W   = COL_W + 1;
    localparam int CC_W   = (CT_W > TCOLS_W) ? CT_W : TCOLS_W;
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int RT_W   = ROW_W + 1;
    localparam int RC_W   = (RT_W > TROWS_W) ? RT_W : TROWS_W;
    localparam int LINE_W = $clog2(MAX_ROWS * GLYPH_HEIGHT);
    localparam int PROD_W = LINE_W + PITCH_W;
    localparam int GH_W   = $clog2(GLYPH_HEIGHT + 1);
    localparam int GLC_W  = (GH_W > GLINE_W) ? GH_W : GLINE_W;
    localparam int GC_W   = CODE_W + 1;

    // configuration
    logic [ADDR_W-1:0]  r_base;
    logic [PITCH_W-1:0] r_pitch;
    logic [TCOLS_W-1:0] r_text_columns;
    logic [TROWS_W-1:0] r_text_rows;
    logic [PIXEL_W-1:0] r_fg;
    logic [PIXEL_W-1:0] r_bg;
    logic               r_enable;

    // sequencer and cursor
    t_state             r_state, n_state;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [Y_W-1:0]     r_y, n_y;
    logic               r_scroll, n_scroll;
    t_kind              r_req_kind, n_req_kind;

    // datapath
    logic [CODE_W-1:0]  r_code, n_code;
    logic [FI_W-1:0]    r_font_idx, n_font_idx;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [ADDR_W-1:0]  r_line_addr, n_line_addr;
    logic [FONT_W-1:0]  r_font_q;
    logic [FONT_W-1:0]  r_font_mem [FONT_DEPTH];

    // output register
    logic               r_out_valid, n_out_valid;
    t_kind              r_out_kind, n_out_kind;
    logic [ADDR_W-1:0]  r_out_addr, n_out_addr;
    logic [FONT_W-1:0]  r_out_bits, n_out_bits;
    logic               r_out_last, n_out_last;

    logic               in_acc;
    logic               out_free;
    logic               out_load;
    logic               rd_en;
    logic               font_we;
    logic [FI_W-1:0]    wr_idx;
    logic [FI_W-1:0]    g_base;
    logic [CODE_W-1:0]  glyph;
    logic               is_ctrl;
    logic               y_last;
    logic [CODE_W-1:0]  sel_code;
    logic [CC_W-1:0]    cols;
    logic [RC_W-1:0]    rows;
    logic [CT_W-1:0]    t_col;
    logic [RT_W-1:0]    t_row;
    logic [COL_W-1:0]   mv_col;
    logic [ROW_W-1:0]   mv_row;
    logic               mv_scroll;
    logic [LINE_W-1:0]  line0;
    logic [PIXEL_W-1:0] pix [PIXELS];

    assign i_char.ready = (r_state == S_IDLE);
    assign in_acc   = i_char.valid & i_char.ready;
    assign out_free = ~r_out_valid | o_req.ready;
    assign y_last   = (r_y == Y_W'(GLYPH_HEIGHT - 1));

    assign is_ctrl = (i_char.char_code == CHAR_LF) || (i_char.char_code == CHAR_CR) ||
                     (i_char.char_code == CHAR_TAB);

    // glyph index and font addressing
    always_comb begin
        if (GC_W'(i_char.char_code) >= GC_W'(GLYPH_COUNT)) begin
            glyph = CODE_W'(GC_W'(i_char.char_code) - GC_W'(GLYPH_COUNT));
        end else begin
            glyph = i_char.char_code;
        end
        g_base  = FI_W'(FI_W'(glyph) * FI_W'(GLYPH_HEIGHT));
        wr_idx  = g_base + FI_W'(i_char.glyph_line);
        font_we = in_acc && (i_char.action == ACT_LOAD) &&
                  (GLC_W'(i_char.glyph_line) < GLC_W'(GLYPH_HEIGHT));
    end

    // clamped geometry
    always_comb begin
        if (r_text_columns == '0) begin
            cols = CC_W'(1);
        end else if (CC_W'(r_text_columns) > CC_W'(MAX_COLUMNS)) begin
            cols = CC_W'(MAX_COLUMNS);
        end else begin
            cols = CC_W'(r_text_columns);
        end
        if (r_text_rows == '0) begin
            rows = RC_W'(1);
        end else if (RC_W'(r_text_rows) > RC_W'(MAX_ROWS)) begin
            rows = RC_W'(MAX_ROWS);
        end else begin
            rows = RC_W'(r_text_rows);
        end
    end

    // cursor move, wrap and scroll
    always_comb begin
        sel_code = (r_state == S_IDLE) ? i_char.char_code : r_code;
        t_row    = RT_W'(r_row);
        case (sel_code)
            CHAR_LF: begin
                t_col = '0;
                t_row = RT_W'(r_row) + RT_W'(1);
            end
            CHAR_CR: begin
                t_col = '0;
            end
            CHAR_TAB: begin
                t_col = (CT_W'(r_col) + CT_W'(TAB_STEP)) & ~CT_W'(TAB_STEP - 1);
            end
            default: begin
                t_col = CT_W'(r_col) + CT_W'(1);
            end
        endcase
        if (CC_W'(t_col) >= cols) begin
            t_col = '0;
            t_row = t_row + RT_W'(1);
        end
        mv_scroll = (RC_W'(t_row) >= rows);
        if (mv_scroll) begin
            t_row = RT_W'(rows - RC_W'(1));
        end
        mv_col = COL_W'(t_col);
        mv_row = ROW_W'(t_row);
    end

    assign line0 = LINE_W'(LINE_W'(r_row) * LINE_W'(GLYPH_HEIGHT));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && r_enable) begin
                    if (i_char.action == ACT_PUT) begin
                        if (!is_ctrl) begin
                            n_state = S_PROD;
                        end else if (mv_scroll) begin
                            n_state = S_REQ;
                        end
                    end else if (i_char.action == ACT_CLEAR) begin
                        n_state = S_REQ;
                    end
                end
            end
            S_PROD: n_state = S_ADDR;
            S_ADDR: n_state = S_DRAW;
            S_DRAW: begin
                if (out_free && y_last) begin
                    n_state = r_scroll ? S_REQ : S_IDLE;
                end
            end
            S_REQ: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_y         = r_y;
        n_scroll    = r_scroll;
        n_req_kind  = r_req_kind;
        n_code      = r_code;
        n_font_idx  = r_font_idx;
        n_prod      = r_prod;
        n_line_addr = r_line_addr;
        n_out_kind  = r_out_kind;
        n_out_addr  = r_out_addr;
        n_out_bits  = r_out_bits;
        n_out_last  = r_out_last;
        out_load    = 1'b0;
        rd_en       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc && r_enable) begin
                    if (i_char.action == ACT_PUT) begin
                        if (is_ctrl) begin
                            n_col      = mv_col;
                            n_row      = mv_row;
                            n_req_kind = KIND_SCROLL;
                        end else begin
                            n_code     = i_char.char_code;
                            n_font_idx = g_base;
                        end
                    end else if (i_char.action == ACT_CLEAR) begin
                        n_col      = '0;
                        n_row      = '0;
                        n_req_kind = KIND_CLEAR;
                    end
                end
            end
            S_PROD: begin
                n_prod = PROD_W'(line0) * PROD_W'(r_pitch);
            end
            S_ADDR: begin
                n_line_addr = r_base + ADDR_W'(r_prod) +
                              (ADDR_W'(r_col) << CELL_SHIFT);
                rd_en       = 1'b1;
                n_font_idx  = r_font_idx + FI_W'(1);
                n_col       = mv_col;
                n_row       = mv_row;
                n_scroll    = mv_scroll;
                n_y         = '0;
            end
            S_DRAW: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    n_out_kind  = KIND_GLYPH;
                    n_out_addr  = r_line_addr;
                    n_out_bits  = r_font_q;
                    n_out_last  = y_last && !r_scroll;
                    n_line_addr = r_line_addr + ADDR_W'(r_pitch);
                    n_y         = r_y + Y_W'(1);
                    n_req_kind  = KIND_SCROLL;
                    if (!y_last) begin
                        rd_en      = 1'b1;
                        n_font_idx = r_font_idx + FI_W'(1);
                    end
                end
            end
            S_REQ: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    n_out_kind = r_req_kind;
                    n_out_addr = r_base;
                    n_out_bits = '0;
                    n_out_last = 1'b1;
                end
            end
            default: ;
        endcase
        n_out_valid = out_load | (r_out_valid & ~o_req.ready);
    end

    // control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_col          <= '0;
            r_row          <= '0;
            r_y            <= '0;
            r_scroll       <= 1'b0;
            r_req_kind     <= KIND_CLEAR;
            r_out_valid    <= 1'b0;
            r_base         <= '0;
            r_pitch        <= '0;
            r_text_columns <= TEXT_COLUMNS_RST;
            r_text_rows    <= TEXT_ROWS_RST;
            r_fg           <= FG_COLOR_RST;
            r_bg           <= '0;
            r_enable       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_y         <= n_y;
            r_scroll    <= n_scroll;
            r_req_kind  <= n_req_kind;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE_ADDRESS: r_base         <= i_cfg_data[ADDR_W-1:0];
                    CFG_LINE_PITCH:   r_pitch        <= i_cfg_data[PITCH_W-1:0];
                    CFG_TEXT_COLUMNS: r_text_columns <= i_cfg_data[TCOLS_W-1:0];
                    CFG_TEXT_ROWS:    r_text_rows    <= i_cfg_data[TROWS_W-1:0];
                    CFG_FG_COLOR:     r_fg           <= i_cfg_data[PIXEL_W-1:0];
                    CFG_BG_COLOR:     r_bg           <= i_cfg_data[PIXEL_W-1:0];
                    CFG_ENABLE:       r_enable       <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_code      <= n_code;
        r_font_idx  <= n_font_idx;
        r_prod      <= n_prod;
        r_line_addr <= n_line_addr;
        r_out_kind  <= n_out_kind;
        r_out_addr  <= n_out_addr;
        r_out_bits  <= n_out_bits;
        r_out_last  <= n_out_last;
    end

    // font RAM
    always_ff @(posedge i_clk) begin
        if (font_we) begin
            r_font_mem[wr_idx] <= i_char.font_bits;
        end
        if (rd_en) begin
            r_font_q <= r_font_mem[r_font_idx];
        end
    end

    // expand glyph bits, MSB leftmost
    always_comb begin
        for (int k = 0; k < PIXELS; k++) begin
            if (r_out_kind == KIND_GLYPH) begin
                pix[k] = r_out_bits[PIXELS-1-k] ? r_fg : r_bg;
            end else begin
                pix[k] = '0;
            end
        end
    end

    assign o_req.valid         = r_out_valid;
    assign o_req.kind          = r_out_kind;
    assign o_req.pixel_address = r_out_addr;
    assign o_req.pixel_0       = pix[0];
    assign o_req.pixel_1       = pix[1];
    assign o_req.pixel_2       = pix[2];
    assign o_req.pixel_3       = pix[3];
    assign o_req.pixel_4       = pix[4];
    assign o_req.pixel_5       = pix[5];
    assign o_req.pixel_6       = pix[6];
    assign o_req.pixel_7       = pix[7];
    assign o_req.last          = r_out_last;

endmodule
